/* hdl/assert_macros.svh */
// Concurrent assertion helpers, empty for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_AT(lbl, clk, rstn, prop)

`define ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

/* hdl/irpd_pkg.sv */
package irpd_pkg;

  localparam int unsigned TICK_COUNTER_BITS_DEF = 16;
  localparam int unsigned MSG_BITS = 32;
  localparam int unsigned ONE_MIN_TICKS = 150;
  localparam int unsigned ONE_MAX_TICKS = 249;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_ADDRESS = 1'd1;

  localparam logic [15:0] TIMEOUT_TICKS_RST    = 16'd1500;
  localparam logic [7:0]  EXPECTED_ADDRESS_RST = 8'd0;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_RISE  = 3'd2,
    PH_HIGH  = 3'd3,
    PH_LOW   = 3'd4,
    PH_TRAIL = 3'd5
  } phase_e;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [7:0]  expected_address;
  } cfg_t;

  typedef struct packed {
    logic [7:0] address;
    logic [7:0] data;
    logic       valid_res;
  } res_t;

endpackage

/* hdl/irpd_channels.sv */
interface irpd_in_if;
  logic valid;
  logic ready;
  logic ir_level;

  modport source (output valid, output ir_level, input ready);
  modport sink (input valid, input ir_level, output ready);
endinterface

interface irpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] address;
  logic [7:0] data;
  logic       valid_res;

  modport source (output valid, output address, output data, output valid_res, input ready);
  modport sink (input valid, input address, input data, input valid_res, output ready);
endinterface

interface irpd_cfg_if
  import irpd_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

/* hdl/irpd_frame_fsm.sv */
`include "assert_macros.svh"

module irpd_frame_fsm
  import irpd_pkg::*;
#(
  parameter int unsigned TICK_COUNTER_BITS = TICK_COUNTER_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  logic ir_level_i,
  input  cfg_t cfg_i,
  output logic emit_o,
  output res_t res_o
);

  localparam int unsigned CMP_W = (TICK_COUNTER_BITS > 16) ? TICK_COUNTER_BITS : 16;
  localparam logic [TICK_COUNTER_BITS-1:0] TICK_MAX = {TICK_COUNTER_BITS{1'b1}};
  localparam logic [TICK_COUNTER_BITS-1:0] ONE_MIN = TICK_COUNTER_BITS'(ONE_MIN_TICKS);
  localparam logic [TICK_COUNTER_BITS-1:0] ONE_MAX = TICK_COUNTER_BITS'(ONE_MAX_TICKS);

  phase_e                       phase_q, phase_d;
  logic [TICK_COUNTER_BITS-1:0] elapsed_q, elapsed_d, elapsed_inc;
  logic [5:0]                   bit_idx_q, bit_idx_d, bit_idx_inc;
  logic [MSG_BITS-1:0]          buf_q, buf_d;
  logic [MSG_BITS-1:0]          prev_q, prev_d;
  logic                         tmo_q, tmo_d;

  logic tmo_hit, active, hold_high, tmo_ev, rise_ev, frame_go, last_bit, bit_one, emit;

  assign elapsed_inc = (elapsed_q == TICK_MAX) ? elapsed_q : elapsed_q + 1'b1;
  assign tmo_hit     = CMP_W'(elapsed_inc) >= CMP_W'(cfg_i.timeout_ticks);
  assign active      = (phase_q == PH_HIGH) || (phase_q == PH_LOW);
  assign hold_high   = (phase_q == PH_HIGH) && ir_level_i;
  assign tmo_ev      = active && !hold_high && tmo_hit;
  assign rise_ev     = (phase_q == PH_LOW) && ir_level_i && !tmo_hit;
  assign frame_go    = (phase_q == PH_RISE) && ir_level_i;
  assign bit_idx_inc = bit_idx_q + 6'd1;
  assign last_bit    = bit_idx_inc[5];
  assign bit_one     = (elapsed_inc >= ONE_MIN) && (elapsed_inc <= ONE_MAX);
  assign emit        = !ir_level_i && (tmo_ev || (phase_q == PH_TRAIL));

  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_START: if (!ir_level_i) phase_d = PH_RISE;
      PH_RISE:  if (ir_level_i) phase_d = PH_HIGH;
      PH_HIGH: begin
        if (!ir_level_i) begin
          phase_d = tmo_hit ? PH_IDLE : PH_LOW;
        end
      end
      PH_LOW: begin
        if (tmo_hit) begin
          phase_d = ir_level_i ? PH_TRAIL : PH_IDLE;
        end else if (ir_level_i) begin
          phase_d = last_bit ? PH_TRAIL : PH_HIGH;
        end
      end
      PH_TRAIL: if (!ir_level_i) phase_d = PH_IDLE;
      default:  phase_d = ir_level_i ? PH_START : PH_IDLE;
    endcase
  end

  always_comb begin
    elapsed_d = elapsed_q;
    bit_idx_d = bit_idx_q;
    buf_d     = buf_q;
    tmo_d     = tmo_q;
    prev_d    = prev_q;
    if (frame_go) begin
      elapsed_d = '0;
      bit_idx_d = '0;
      buf_d     = '0;
      tmo_d     = 1'b0;
    end
    if (active) begin
      elapsed_d = rise_ev ? '0 : elapsed_inc;
    end
    if (tmo_ev) begin
      buf_d = prev_q;
      tmo_d = 1'b1;
    end
    if (rise_ev) begin
      buf_d     = {buf_q[MSG_BITS-2:0], bit_one};
      bit_idx_d = bit_idx_inc;
    end
    if (emit) begin
      prev_d = buf_d;
    end
  end

  always_comb begin
    emit_o          = step_i && emit;
    res_o.address   = buf_d[31:24];
    res_o.data      = buf_d[15:8];
    res_o.valid_res = !tmo_d && (buf_d[31:24] == cfg_i.expected_address) &&
                      (buf_d[31:24] == ~buf_d[23:16]) && (buf_d[15:8] == ~buf_d[7:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      elapsed_q <= '0;
      bit_idx_q <= '0;
      buf_q     <= '0;
      prev_q    <= '0;
      tmo_q     <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      bit_idx_q <= bit_idx_d;
      buf_q     <= buf_d;
      prev_q    <= prev_d;
      tmo_q     <= tmo_d;
    end
  end

  `ASSERT_AT(a_emit_to_idle, clk_i, rst_ni, emit_o |=> phase_q == PH_IDLE)
  `ASSERT_NEVER(a_bit_idx_range, clk_i, rst_ni, bit_idx_q > 6'd32)
  `ASSERT_NEVER(a_tmo_never_valid, clk_i, rst_ni, emit_o && tmo_d && res_o.valid_res)
  `ASSERT_AT(a_emit_saves_msg, clk_i, rst_ni, emit_o |=> prev_q == $past(buf_d))

endmodule

/* hdl/ir_pulse_distance_decoder_core.sv */
// Channel  | Dir | Payload                        | Accepted when
// in_if    | in  | ir_level                       | valid & ready
// out_if   | out | address, data, valid_res       | valid & ready
// cfg_if   | in  | index, wdata                   | valid & ready (ready tied high)
//
// One line sample a cycle unless ready is low: the frame state advances as it is taken.
// The frame's last sample registers its result in the output register, or in the skid.
// A two-entry result buffer (output register and skid) parts the two sides;
// in_if.ready drops only while the skid entry is occupied.
// rst_ni clears the frame state, the result buffer and the registers to their defaults.
`include "assert_macros.svh"

module ir_pulse_distance_decoder_core
  import irpd_pkg::*;
#(
  parameter int unsigned TICK_COUNTER_BITS = TICK_COUNTER_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  irpd_in_if.sink    in_if,
  irpd_out_if.source out_if,
  irpd_cfg_if.sink   cfg_if
);

  cfg_t cfg_q, cfg_d;
  res_t res, out_res_q, out_res_d, skid_res_q, skid_res_d;
  logic out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic step, emit, cfg_wr;

  assign in_if.ready  = !skid_valid_q;
  assign step         = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;
  assign cfg_wr       = cfg_if.valid && cfg_if.ready;

  irpd_frame_fsm #(
    .TICK_COUNTER_BITS(TICK_COUNTER_BITS)
  ) u_fsm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .ir_level_i (in_if.ir_level),
    .cfg_i      (cfg_q),
    .emit_o     (emit),
    .res_o      (res)
  );

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (cfg_if.index)
        REG_TIMEOUT_TICKS:    cfg_d.timeout_ticks = cfg_if.wdata;
        REG_EXPECTED_ADDRESS: cfg_d.expected_address = cfg_if.wdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    out_res_d    = out_res_q;
    skid_valid_d = skid_valid_q;
    skid_res_d   = skid_res_q;
    if (out_valid_q && out_if.ready) begin
      if (skid_valid_q) begin
        out_res_d    = skid_res_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = emit;
        out_res_d   = res;
      end
    end else if (!out_valid_q) begin
      out_valid_d = emit;
      out_res_d   = res;
    end else if (emit) begin
      skid_valid_d = 1'b1;
      skid_res_d   = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ticks    <= TIMEOUT_TICKS_RST;
      cfg_q.expected_address <= EXPECTED_ADDRESS_RST;
      out_valid_q            <= 1'b0;
      skid_valid_q           <= 1'b0;
    end else begin
      cfg_q        <= cfg_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q  <= out_res_d;
    skid_res_q <= skid_res_d;
  end

  assign out_if.valid     = out_valid_q;
  assign out_if.address   = out_res_q.address;
  assign out_if.data      = out_res_q.data;
  assign out_if.valid_res = out_res_q.valid_res;

  `ASSERT_AT(a_skid_needs_out, clk_i, rst_ni, skid_valid_q |-> out_valid_q)
  `ASSERT_AT(a_stall_fills_skid, clk_i, rst_ni, out_valid_q && !out_if.ready && emit |=> skid_valid_q)
  `ASSERT_AT(a_cfg_timeout_wr, clk_i, rst_ni,
    cfg_wr && (cfg_if.index == REG_TIMEOUT_TICKS) |=> cfg_q.timeout_ticks == $past(cfg_if.wdata))

endmodule
